[rtl/brlt_pkg.sv]
// Shared types, constants and Horner coefficient tables for the
// stochastic-reset Brownian local-time block. No dependencies.
package brlt_pkg;

	localparam int NUM_BINS  = 32768;
	localparam int BIN_W     = $clog2(NUM_BINS);
	localparam int FRAC_BITS = 24;
	localparam int LOG_FRAC  = 28;
	localparam int NOISE_W   = 29;
	localparam int RAD_W     = 27;
	localparam int SQ_IN_W   = 2 * RAD_W;
	localparam int MUL_A_W   = 34;
	localparam int MUL_B_W   = 32;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int DIV_W     = 24;

	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
	localparam logic [23:0] MASK24      = 24'hFF_FFFF;

	localparam logic [24:0] DRIFT_RST  = 25'd1845;
	localparam logic [24:0] NSCALE_RST = 25'd167772;
	localparam logic [31:0] THRESH_RST = 32'd0;
	localparam logic [29:0] RPOS_RST   = 30'd16777216;
	localparam logic [24:0] WHALF_RST  = 25'd83886;
	localparam logic [23:0] MAXS_RST   = 24'd200001;
	localparam logic [15:0] SPB_RST    = 16'd10;

	typedef enum logic [2:0] {
		REG_DRIFT     = 3'd0,
		REG_NSCALE    = 3'd1,
		REG_THRESH    = 3'd2,
		REG_RPOS      = 3'd3,
		REG_WHALF     = 3'd4,
		REG_MAX_STEPS = 3'd5,
		REG_STEPS_BIN = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] uniform_a;
		logic [31:0] uniform_b;
		logic [31:0] uniform_c;
		logic [14:0] bin_index;
	} in_item_t;

	typedef struct packed {
		logic        kind_echo;
		logic        realization_done;
		logic        absorbed;
		logic [23:0] local_count;
		logic [31:0] position;
		logic [31:0] bin_count;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [31:0] uniform_a;
		logic [31:0] uniform_b;
		logic [24:0] noise_scale;
	} noise_req_t;

	typedef struct packed {
		logic               done;
		logic [NOISE_W-1:0] noise;
	} noise_rsp_t;

	// ceil(2^s / k) with s = 30 + ceil(log2 k): exact floor division for n < 2^30
	function automatic logic [30:0] hor_recip(input logic sin_sel, input logic [2:0] idx);
		logic [30:0] r;
		r = '0;
		if (!sin_sel) begin
			case (idx)
				3'd0: r = 31'd2082408386;
				3'd1: r = 31'd1527099484;
				3'd2: r = 31'd1227133514;
				3'd3: r = 31'd1145324613;
				3'd4: r = 31'd1431655766;
				3'd5: r = 31'd1073741824;
				default: r = '0;
			endcase
		end else begin
			case (idx)
				3'd0: r = 31'd1249445032;
				3'd1: r = 31'd1908874354;
				3'd2: r = 31'd1636178018;
				3'd3: r = 31'd1717986919;
				3'd4: r = 31'd1431655766;
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	function automatic logic [5:0] hor_shift(input logic sin_sel, input logic [2:0] idx);
		logic [5:0] s;
		s = '0;
		if (!sin_sel) begin
			case (idx)
				3'd0: s = 6'd38;
				3'd1: s = 6'd37;
				3'd2: s = 6'd36;
				3'd3: s = 6'd35;
				3'd4: s = 6'd34;
				3'd5: s = 6'd31;
				default: s = '0;
			endcase
		end else begin
			case (idx)
				3'd0: s = 6'd37;
				3'd1: s = 6'd37;
				3'd2: s = 6'd36;
				3'd3: s = 6'd35;
				3'd4: s = 6'd33;
				default: s = '0;
			endcase
		end
		return s;
	endfunction

	function automatic logic [2:0] hor_last(input logic sin_sel);
		return sin_sel ? 3'd4 : 3'd5;
	endfunction

endpackage

[rtl/brlt_in_if.sv]
// Input channel: valid/ready handshake carrying one step or read item.
// Depends on brlt_pkg.
interface brlt_in_if;
	import brlt_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/brlt_out_if.sv]
// Output channel: valid/ready handshake carrying one result item.
// Depends on brlt_pkg.
interface brlt_out_if;
	import brlt_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/brlt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module brlt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/brlt_isqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
// Depends on brlt_pkg.
module brlt_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [brlt_pkg::SQ_IN_W-1:0] value,
	output logic [brlt_pkg::RAD_W-1:0]   root,
	output logic                         done
);
	import brlt_pkg::*;

	localparam int REM_W = RAD_W + 4;
	localparam int CNT_W = $clog2(RAD_W + 1);

	logic [SQ_IN_W-1:0] v_q;
	logic [REM_W-1:0]   rem_q;
	logic [RAD_W-1:0]   root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [REM_W-1:0] rsh;
	logic [REM_W-1:0] trial;
	logic             ge;

	always_comb begin
		rsh   = {rem_q[REM_W-3:0], v_q[SQ_IN_W-1 -: 2]};
		trial = REM_W'({root_q, 2'b01});
		ge    = rsh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			v_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			v_q    <= {v_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= ge ? rsh - trial : rsh;
			root_q <= {root_q[RAD_W-2:0], ge};
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(RAD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("sqrt done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && !done_q) else $error("sqrt did not start");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q) else $error("sqrt stopped without done");

endmodule

[rtl/brlt_noise.sv]
// Box-Muller noise unit: log by repeated squaring, cosine by a Horner series
// for cos or sin, all on one shared registered multiplier; sqrt runs
// alongside in brlt_isqrt. Depends on brlt_pkg and brlt_isqrt.
module brlt_noise (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brlt_pkg::noise_req_t nreq,
	output brlt_pkg::noise_rsp_t nrsp
);
	import brlt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_LSQ, S_LFX, S_NL, S_NLW, S_X, S_XW, S_X2, S_X2W,
		S_H1, S_H2, S_H3, S_SN, S_SNW, S_RC, S_RCW, S_NS, S_NSW
	} state_t;

	state_t             state_q;
	logic [31:0]        m_q;
	logic [4:0]         p_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [4:0]         cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [30:0]        arg_q;
	logic               sin_q;
	logic               neg_q;
	logic [30:0]        x_q;
	logic [29:0]        x2_q;
	logic [30:0]        t_q;
	logic [2:0]         k_q;
	logic [RAD_W-1:0]   g_q;
	logic [24:0]        ns_q;
	logic               sq_start_q;
	logic [SQ_IN_W-1:0] sq_value_q;
	logic               done_q;
	logic [NOISE_W-1:0] noise_q;

	logic [RAD_W-1:0]   radius;
	logic               sq_done;

	logic [31:0]        u0, u1, u2, u3, u4, u5;
	logic [4:0]         sh;
	logic [30:0]        fa;
	logic               fa_sin;
	logic [5:0]         lz;
	logic [33:0]        nl;
	logic [32:0]        mv;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [27:0]        e;

	always_comb begin
		u0 = (nreq.uniform_a == '0) ? 32'd1 : nreq.uniform_a;
		sh[4] = (u0[31:16] == '0);
		u1 = sh[4] ? {u0[15:0], 16'b0} : u0;
		sh[3] = (u1[31:24] == '0);
		u2 = sh[3] ? {u1[23:0], 8'b0} : u1;
		sh[2] = (u2[31:28] == '0);
		u3 = sh[2] ? {u2[27:0], 4'b0} : u2;
		sh[1] = (u3[31:30] == '0);
		u4 = sh[1] ? {u3[29:0], 2'b0} : u3;
		sh[0] = !u4[31];
		u5 = sh[0] ? {u4[30:0], 1'b0} : u4;
		fa = nreq.uniform_b[30] ? ONE_Q30 - {1'b0, nreq.uniform_b[29:0]}
			: {1'b0, nreq.uniform_b[29:0]};
		fa_sin = fa > (ONE_Q30 >> 1);
		lz = 6'd32 - {1'b0, p_q};
		nl = {lz, 28'b0} - {6'b0, frac_q};
		mv = prod_q[63:31];
		e  = 28'(prod_q >> FRAC_BITS);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_LSQ: begin
				mul_a = MUL_A_W'(m_q);
				mul_b = m_q;
			end
			S_NL: begin
				mul_a = nl;
				mul_b = TWO_LN2_Q30;
			end
			S_X: begin
				mul_a = MUL_A_W'(arg_q);
				mul_b = HALF_PI_Q30;
			end
			S_X2: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = MUL_B_W'(x_q);
			end
			S_H1: begin
				mul_a = MUL_A_W'(x2_q);
				mul_b = MUL_B_W'(t_q);
			end
			S_H2: begin
				mul_a = MUL_A_W'(prod_q[59:30]);
				mul_b = MUL_B_W'(hor_recip(sin_q, k_q));
			end
			S_SN: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = MUL_B_W'(t_q);
			end
			S_RC: begin
				mul_a = MUL_A_W'(radius);
				mul_b = MUL_B_W'(t_q);
			end
			S_NS: begin
				mul_a = MUL_A_W'(g_q);
				mul_b = MUL_B_W'(ns_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_q        <= '0;
			p_q        <= '0;
			frac_q     <= '0;
			cnt_q      <= '0;
			prod_q     <= '0;
			arg_q      <= '0;
			sin_q      <= 1'b0;
			neg_q      <= 1'b0;
			x_q        <= '0;
			x2_q       <= '0;
			t_q        <= '0;
			k_q        <= '0;
			g_q        <= '0;
			ns_q       <= '0;
			sq_start_q <= 1'b0;
			sq_value_q <= '0;
			done_q     <= 1'b0;
			noise_q    <= '0;
		end else begin
			prod_q     <= PROD_W'(mul_a) * PROD_W'(mul_b);
			sq_start_q <= 1'b0;
			done_q     <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (nreq.start) begin
						m_q     <= u5;
						p_q     <= ~sh;
						frac_q  <= '0;
						cnt_q   <= '0;
						sin_q   <= fa_sin;
						arg_q   <= fa_sin ? ONE_Q30 - fa : fa;
						neg_q   <= nreq.uniform_b[31] ^ nreq.uniform_b[30];
						ns_q    <= nreq.noise_scale;
						state_q <= S_LSQ;
					end
				end
				S_LSQ: state_q <= S_LFX;
				S_LFX: begin
					frac_q <= {frac_q[LOG_FRAC-2:0], mv[32]};
					m_q    <= mv[32] ? mv[32:1] : mv[31:0];
					cnt_q  <= cnt_q + 1'b1;
					state_q <= (cnt_q == 5'(LOG_FRAC - 1)) ? S_NL : S_LSQ;
				end
				S_NL: state_q <= S_NLW;
				S_NLW: begin
					sq_value_q <= {prod_q[63:30], 20'b0};
					sq_start_q <= 1'b1;
					state_q    <= S_X;
				end
				S_X: state_q <= S_XW;
				S_XW: begin
					x_q     <= prod_q[60:30];
					state_q <= S_X2;
				end
				S_X2: state_q <= S_X2W;
				S_X2W: begin
					x2_q    <= prod_q[59:30];
					t_q     <= ONE_Q30;
					k_q     <= '0;
					state_q <= S_H1;
				end
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: begin
					t_q <= ONE_Q30 - 31'(prod_q >> hor_shift(sin_q, k_q));
					if (k_q == hor_last(sin_q)) begin
						state_q <= sin_q ? S_SN : S_RC;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_H1;
					end
				end
				S_SN: state_q <= S_SNW;
				S_SNW: begin
					t_q     <= prod_q[60:30];
					state_q <= S_RC;
				end
				S_RC: begin
					if (sq_done && !sq_start_q) begin
						state_q <= S_RCW;
					end
				end
				S_RCW: begin
					g_q     <= RAD_W'(prod_q >> (54 - FRAC_BITS));
					state_q <= S_NS;
				end
				S_NS: state_q <= S_NSW;
				S_NSW: begin
					noise_q <= neg_q ? -{1'b0, e} : {1'b0, e};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	brlt_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.value  (sq_value_q),
		.root   (radius),
		.done   (sq_done)
	);

	assign nrsp.done  = done_q;
	assign nrsp.noise = noise_q;

	a_rc_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RCW |-> $past(sq_done)) else $error("radius used before sqrt done");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("noise done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE) else $error("noise done outside idle");

endmodule

[rtl/brownian_reset_local_time_mc.sv]
// Top level: Brownian particle with stochastic reset, absorbing wall at zero,
// and a local-time histogram. Depends on brlt_pkg, brlt_in_if, brlt_out_if,
// brlt_ram and brlt_noise.
//
// Items enter on req (valid/ready) and each gives exactly one result on rsp.
// A step item (kind 0) carries three uniform samples; a read item (kind 1)
// names a histogram bin. Registers are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while the block is idle (the block does
// not enforce this), and writes apply from the next step. One item is worked
// at a time; req.ready rises in the same cycle that a result appears. A read
// item reads its bin in T_RRD and then passes to T_FIN. A step item waits on
// the noise unit, whose time is set by the 28 squaring rounds of the log on
// the shared multiplier and the serial square root that follows; a step that
// ends a realization also runs the serial bin divider and the histogram
// read-modify-write. After reset the histogram memory is cleared one entry
// per cycle over all 32768 entries, during which req.ready stays low.
// The result sits in an output register; a new item is taken while it waits,
// and the next result is held until rsp.ready takes the previous one.
module brownian_reset_local_time_mc (
	input  logic        clk,
	input  logic        arst_n,
	brlt_in_if.sink     req,
	brlt_out_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import brlt_pkg::*;

	typedef enum logic [3:0] {
		T_CLEAR, T_IDLE, T_RRD, T_NOISE, T_UPD, T_WIN,
		T_DIV, T_HRD, T_HWT, T_FIN
	} state_t;

	state_t              state_q;
	logic [BIN_W-1:0]    clr_q;
	logic [BIN_W-1:0]    bin_q;
	in_item_t            item_q;
	logic [31:0]         pos_q;
	logic [23:0]         ws_q;
	logic [23:0]         steps_q;
	logic [NOISE_W-1:0]  noise_val_q;
	logic                start_q;
	logic [DIV_W-1:0]    dvd_q;
	logic [15:0]         drem_q;
	logic [4:0]          div_cnt_q;
	out_item_t           res_q;
	out_item_t           out_q;
	logic                out_valid_q;

	logic [24:0]         drift_q;
	logic [24:0]         nscale_q;
	logic [31:0]         thresh_q;
	logic [29:0]         rpos_q;
	logic [24:0]         whalf_q;
	logic [23:0]         maxs_q;
	logic [15:0]         spb_q;

	noise_req_t          nreq;
	noise_rsp_t          nrsp;

	logic                ram_we;
	logic [BIN_W-1:0]    ram_waddr;
	logic [31:0]         ram_wdata;
	logic [BIN_W-1:0]    ram_raddr;
	logic [31:0]         ram_rdata;

	logic [33:0]         sum;
	logic [31:0]         x_new;
	logic [23:0]         steps_inc;
	logic [34:0]         posx, win_lo, win_hi;
	logic                in_win;
	logic                abs_w;
	logic                done_w;
	logic [23:0]         ws_next;
	logic [23:0]         limit;
	logic [15:0]         per;
	logic [16:0]         dr;
	logic                dge;
	logic [BIN_W-1:0]    bin_sel;
	logic                rd_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_q  <= DRIFT_RST;
			nscale_q <= NSCALE_RST;
			thresh_q <= THRESH_RST;
			rpos_q   <= RPOS_RST;
			whalf_q  <= WHALF_RST;
			maxs_q   <= MAXS_RST;
			spb_q    <= SPB_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DRIFT:     drift_q  <= cfg_data[24:0];
				REG_NSCALE:    nscale_q <= cfg_data[24:0];
				REG_THRESH:    thresh_q <= cfg_data;
				REG_RPOS:      rpos_q   <= cfg_data[29:0];
				REG_WHALF:     whalf_q  <= cfg_data[24:0];
				REG_MAX_STEPS: maxs_q   <= cfg_data[23:0];
				REG_STEPS_BIN: spb_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sum = {{2{pos_q[31]}}, pos_q} + {{9{drift_q[24]}}, drift_q}
			+ {{5{noise_val_q[NOISE_W-1]}}, noise_val_q};
		if (item_q.uniform_c < thresh_q) begin
			x_new = {2'b00, rpos_q};
		end else if (!sum[33] && (sum[32] || sum[31])) begin
			x_new = 32'h7FFF_FFFF;
		end else if (sum[33] && !(sum[32] && sum[31])) begin
			x_new = 32'h8000_0000;
		end else begin
			x_new = sum[31:0];
		end
		steps_inc = (steps_q != MASK24) ? steps_q + 1'b1 : steps_q;

		posx   = {{3{pos_q[31]}}, pos_q};
		win_lo = {5'b0, rpos_q} - {10'b0, whalf_q};
		win_hi = {5'b0, rpos_q} + {10'b0, whalf_q};
		in_win = ($signed(posx) > $signed(win_lo)) && ($signed(posx) < $signed(win_hi));
		abs_w  = !in_win && pos_q[31];
		ws_next = (in_win && ws_q != MASK24) ? ws_q + 1'b1 : ws_q;
		limit  = (maxs_q == '0) ? 24'd1 : maxs_q;
		done_w = abs_w || (steps_q >= limit);

		per = (spb_q == '0) ? 16'd1 : spb_q;
		dr  = {drem_q, dvd_q[DIV_W-1]};
		dge = dr >= {1'b0, per};
		bin_sel = ({8'b0, dvd_q} > 32'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
			: BIN_W'(dvd_q);
		rd_ok = {17'b0, item_q.bin_index} < 32'(NUM_BINS);

		ram_we    = (state_q == T_CLEAR) || (state_q == T_HWT);
		ram_waddr = (state_q == T_CLEAR) ? clr_q : bin_q;
		ram_wdata = (state_q == T_CLEAR) ? 32'd0
			: ((ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1);
		ram_raddr = (state_q == T_HRD) ? bin_sel : BIN_W'(req.data.bin_index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_CLEAR;
			clr_q       <= '0;
			bin_q       <= '0;
			item_q      <= '0;
			pos_q       <= 32'(RPOS_RST);
			ws_q        <= '0;
			steps_q     <= '0;
			noise_val_q <= '0;
			start_q     <= 1'b0;
			dvd_q       <= '0;
			drem_q      <= '0;
			div_cnt_q   <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIN_W'(NUM_BINS - 1)) begin
						state_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (req.valid) begin
						item_q <= req.data;
						if (req.data.kind) begin
							state_q <= T_RRD;
						end else begin
							start_q <= 1'b1;
							state_q <= T_NOISE;
						end
					end
				end
				T_RRD: begin
					res_q   <= '{kind_echo: 1'b1, realization_done: 1'b0, absorbed: 1'b0,
						local_count: ws_q, position: pos_q,
						bin_count: rd_ok ? ram_rdata : 32'd0};
					state_q <= T_FIN;
				end
				T_NOISE: begin
					if (nrsp.done) begin
						noise_val_q <= nrsp.noise;
						state_q     <= T_UPD;
					end
				end
				T_UPD: begin
					pos_q   <= x_new;
					steps_q <= steps_inc;
					state_q <= T_WIN;
				end
				T_WIN: begin
					ws_q  <= ws_next;
					res_q <= '{kind_echo: 1'b0, realization_done: done_w, absorbed: abs_w,
						local_count: ws_next, position: pos_q, bin_count: 32'd0};
					if (done_w) begin
						dvd_q     <= ws_next;
						drem_q    <= '0;
						div_cnt_q <= '0;
						state_q   <= T_DIV;
					end else begin
						state_q <= T_FIN;
					end
				end
				T_DIV: begin
					drem_q    <= dge ? 16'(dr - {1'b0, per}) : dr[15:0];
					dvd_q     <= {dvd_q[DIV_W-2:0], dge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'(DIV_W - 1)) begin
						state_q <= T_HRD;
					end
				end
				T_HRD: begin
					bin_q   <= bin_sel;
					state_q <= T_HWT;
				end
				T_HWT: begin
					pos_q   <= {2'b00, rpos_q};
					ws_q    <= '0;
					steps_q <= '0;
					state_q <= T_FIN;
				end
				T_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign nreq.start       = start_q;
	assign nreq.uniform_a   = item_q.uniform_a;
	assign nreq.uniform_b   = item_q.uniform_b;
	assign nreq.noise_scale = nscale_q;

	brlt_noise u_noise (
		.clk    (clk),
		.arst_n (arst_n),
		.nreq   (nreq),
		.nrsp   (nrsp)
	);

	brlt_ram #(
		.WIDTH (32),
		.DEPTH (NUM_BINS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == T_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_noise_state: assert property (@(posedge clk) disable iff (!arst_n)
		nrsp.done |-> state_q == T_NOISE) else $error("noise result outside noise wait");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_HWT |=> ws_q == '0 && steps_q == '0) else $error("realization not restarted");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != T_IDLE) else $error("item accepted but not worked");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_FIN && rsp.valid && !rsp.ready |=> state_q == T_FIN)
		else $error("result overwrote a waiting item");

endmodule
